// File: design/dasa_pkg.sv
// ----------------------------------------------------------------------------
// dasa_pkg
// Shared types and constants for the decimal add/subtract ALU pipeline.
// ----------------------------------------------------------------------------
package dasa_pkg;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_SUB = 1'b1;

   localparam logic [4:0] DEC_DIGIT_LIMIT = 5'h0A;
   localparam logic [3:0] DEC_ADJUST      = 4'h6;
   localparam logic [8:0] DEC_HI_LIMIT    = 9'h0A0;
   localparam logic [9:0] DEC_HI_ADJUST   = 10'h060;
   localparam logic [4:0] DEC_HALF_CARRY  = 5'h10;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

// File: design/dasa_datapath.sv
// ----------------------------------------------------------------------------
// dasa_datapath
// Three register stages of binary and packed-BCD add/subtract arithmetic.
// Stage one forms the binary sum and raw digit sums, stage two applies the
// low digit correction and derives the flags, stage three applies the high
// digit correction and selects the result.
// ----------------------------------------------------------------------------
module dasa_datapath (
   input  logic                  clock,
   input  dasa_pkg::stage_en_type en,
   input  logic                  req_func,
   input  logic [7:0]            req_accumulator,
   input  logic [7:0]            req_operand,
   input  logic                  req_carry_in,
   input  logic                  req_decimal_mode,
   output logic [7:0]            rsp_acc_out,
   output logic                  rsp_carry_out,
   output logic                  rsp_negative,
   output logic                  rsp_zero,
   output logic                  rsp_overflow
);

   // Stage one.
   logic       s1_sub_ff, s1_dec_ff, s1_a7_ff, s1_m7_ff;
   logic [8:0] s1_bin_ff, s1_bin_in;
   logic [4:0] s1_add_lo_ff, s1_add_lo_in;
   logic [5:0] s1_sub_lo_ff, s1_sub_lo_in;
   logic [4:0] s1_sub_hi_ff, s1_sub_hi_in;
   logic [3:0] s1_a_hi_ff, s1_m_hi_ff;
   logic [7:0] m_eff;

   always_comb begin
      m_eff        = (req_func == dasa_pkg::FUNC_SUB) ? ~req_operand : req_operand;
      s1_bin_in    = {1'b0, req_accumulator} + {1'b0, m_eff} + {8'd0, req_carry_in};
      s1_add_lo_in = {1'b0, req_accumulator[3:0]} + {1'b0, req_operand[3:0]}
                     + {4'd0, req_carry_in};
      s1_sub_lo_in = {2'b00, req_accumulator[3:0]} - {2'b00, req_operand[3:0]}
                     - {5'd0, ~req_carry_in};
      s1_sub_hi_in = {1'b0, req_accumulator[7:4]} - {1'b0, req_operand[7:4]};
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         s1_sub_ff    <= req_func;
         s1_dec_ff    <= req_decimal_mode;
         s1_a7_ff     <= req_accumulator[7];
         s1_m7_ff     <= m_eff[7];
         s1_bin_ff    <= s1_bin_in;
         s1_add_lo_ff <= s1_add_lo_in;
         s1_sub_lo_ff <= s1_sub_lo_in;
         s1_sub_hi_ff <= s1_sub_hi_in;
         s1_a_hi_ff   <= req_accumulator[7:4];
         s1_m_hi_ff   <= req_operand[7:4];
      end
   end

   // Stage two.
   logic       s2_sub_ff, s2_dec_ff, s2_neg_ff, s2_zero_ff, s2_ovf_ff;
   logic [8:0] s2_bin_ff;
   logic [8:0] s2_add_s_ff, s2_add_s_in;
   logic [3:0] s2_sub_lo_ff, s2_sub_lo_in;
   logic [4:0] s2_sub_hi_ff, s2_sub_hi_in;
   logic [4:0] add_lo_fix;

   always_comb begin
      if (s1_add_lo_ff >= dasa_pkg::DEC_DIGIT_LIMIT) begin
         add_lo_fix = {1'b0, s1_add_lo_ff[3:0] + dasa_pkg::DEC_ADJUST}
                      + dasa_pkg::DEC_HALF_CARRY;
      end else begin
         add_lo_fix = s1_add_lo_ff;
      end
      s2_add_s_in = {1'b0, s1_a_hi_ff, 4'd0} + {1'b0, s1_m_hi_ff, 4'd0}
                    + {4'd0, add_lo_fix};
      if (s1_sub_lo_ff[5]) begin
         s2_sub_lo_in = s1_sub_lo_ff[3:0] - dasa_pkg::DEC_ADJUST;
         s2_sub_hi_in = s1_sub_hi_ff - 5'd1;
      end else begin
         s2_sub_lo_in = s1_sub_lo_ff[3:0];
         s2_sub_hi_in = s1_sub_hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         s2_sub_ff    <= s1_sub_ff;
         s2_dec_ff    <= s1_dec_ff;
         s2_bin_ff    <= s1_bin_ff;
         s2_neg_ff    <= s1_bin_ff[7];
         s2_zero_ff   <= (s1_bin_ff[7:0] == 8'd0);
         s2_ovf_ff    <= (s1_a7_ff ^ s1_bin_ff[7]) & (s1_m7_ff ^ s1_bin_ff[7]);
         s2_add_s_ff  <= s2_add_s_in;
         s2_sub_lo_ff <= s2_sub_lo_in;
         s2_sub_hi_ff <= s2_sub_hi_in;
      end
   end

   // Stage three.
   logic [7:0] s3_acc_ff, s3_acc_in;
   logic       s3_cy_ff, s3_cy_in;
   logic       s3_neg_ff, s3_zero_ff, s3_ovf_ff;
   logic [9:0] add_s_fix;
   logic [3:0] sub_hi_fix;

   always_comb begin
      if (s2_add_s_ff >= dasa_pkg::DEC_HI_LIMIT) begin
         add_s_fix = {1'b0, s2_add_s_ff} + dasa_pkg::DEC_HI_ADJUST;
      end else begin
         add_s_fix = {1'b0, s2_add_s_ff};
      end
      if (s2_sub_hi_ff[4]) begin
         sub_hi_fix = s2_sub_hi_ff[3:0] - dasa_pkg::DEC_ADJUST;
      end else begin
         sub_hi_fix = s2_sub_hi_ff[3:0];
      end
      if (!s2_dec_ff) begin
         s3_acc_in = s2_bin_ff[7:0];
         s3_cy_in  = s2_bin_ff[8];
      end else if (s2_sub_ff == dasa_pkg::FUNC_SUB) begin
         s3_acc_in = {sub_hi_fix, s2_sub_lo_ff};
         s3_cy_in  = ~s2_sub_hi_ff[4];
      end else begin
         s3_acc_in = add_s_fix[7:0];
         s3_cy_in  = |add_s_fix[9:8];
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         s3_acc_ff  <= s3_acc_in;
         s3_cy_ff   <= s3_cy_in;
         s3_neg_ff  <= s2_neg_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_ovf_ff  <= s2_ovf_ff;
      end
   end

   assign rsp_acc_out   = s3_acc_ff;
   assign rsp_carry_out = s3_cy_ff;
   assign rsp_negative  = s3_neg_ff;
   assign rsp_zero      = s3_zero_ff;
   assign rsp_overflow  = s3_ovf_ff;

endmodule

// File: design/decimal_adc_sbc_alu.sv
// ----------------------------------------------------------------------------
// decimal_adc_sbc_alu
// Eight-bit add/subtract with carry in binary or packed-BCD decimal mode.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while the result channel
// keeps up. A transaction passes through a three-stage pipeline whose
// last stage is the output register, so its result is registered in
// stages one and two before it reaches the outputs. A stalled output
// holds the pipeline only as far back as stages are full, so bubbles are
// squeezed out and throughput stays at one transaction per cycle while
// the result channel keeps up.
module decimal_adc_sbc_alu (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_accumulator,
   input  logic [7:0] req_operand,
   input  logic       req_carry_in,
   input  logic       req_decimal_mode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_acc_out,
   output logic       rsp_carry_out,
   output logic       rsp_negative,
   output logic       rsp_zero,
   output logic       rsp_overflow
);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   dasa_pkg::stage_en_type en;

   always_comb begin
      en.s3     = !v3_ff || rsp_ready;
      en.s2     = !v2_ff || en.s3;
      en.s1     = !v1_ff || en.s2;
      req_ready = en.s1;
      v1_in     = en.s1 ? req_valid : v1_ff;
      v2_in     = en.s2 ? v1_ff : v2_ff;
      v3_in     = en.s3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign rsp_valid = v3_ff;

   dasa_datapath u_datapath (
      .clock            (clock),
      .en               (en),
      .req_func         (req_func),
      .req_accumulator  (req_accumulator),
      .req_operand      (req_operand),
      .req_carry_in     (req_carry_in),
      .req_decimal_mode (req_decimal_mode),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_carry_out    (rsp_carry_out),
      .rsp_negative     (rsp_negative),
      .rsp_zero         (rsp_zero),
      .rsp_overflow     (rsp_overflow)
   );

`ifndef SYNTH
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v1_ff)
      else $error("accepted transaction did not enter stage one");

   a_s2_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en.s3) |=> v2_ff)
      else $error("stage two transaction lost during stall");

   a_full_pipe_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while pipeline is full and stalled");
`endif

endmodule
